// ----- hdl/mbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared sizes, codes, command/status structs and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned REG_DEPTH   = 64;
  localparam int unsigned MAX_READ    = 29;

  localparam int unsigned LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned BUF_AW = $clog2(FRAME_BYTES);
  localparam int unsigned REG_AW = $clog2(REG_DEPTH);
  localparam int unsigned LIM_W  = $clog2(REG_DEPTH + 1);

  localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_LWRITE  = 2'd2;
  localparam logic [1:0] FUNC_LREAD   = 2'd3;

  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_EXC_FLAG   = 8'h80;
  localparam logic [7:0] EXC_ILL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ILL_ADDR  = 8'h02;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_REGS_USED  = 2'd1;
  localparam logic [1:0] CFG_GAP_TICKS  = 2'd2;

  localparam logic [7:0] RST_SLAVE_ADDR = 8'd1;
  localparam logic [6:0] RST_REGS_USED  = 7'd64;
  localparam logic [7:0] RST_GAP_TICKS  = 8'd10;

  typedef enum logic [3:0] {
    SEL_ADDR, SEL_FCX, SEL_EXC1, SEL_EXC2, SEL_FC3, SEL_CNT,
    SEL_RHI, SEL_RLO, SEL_BUF, SEL_CRCL, SEL_CRCH
  } sel_e;

  typedef struct packed {
    logic [7:0] slave_addr;
    logic [6:0] regs_used;
    logic [7:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic store_byte;
    logic tick_inc;
    logic clear_frame;
    logic hw_local;
    logic hw_frame;
    logic hr_local;
    logic hr_frame;
    logic buf_rd;
    logic cnt_clr;
    logic cnt_inc;
    logic txcrc_init;
    logic emit;
    logic emit_local;
    logic last;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic frame_due;
    logic hdr_ok;
    logic short8;
    logic is_rd;
    logic is_wr;
    logic rd_fault;
    logic wr_fault;
    logic q_zero;
    logic rd_last;
    logic echo_last;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/mbs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_if
// Valid/ready channels for input events and result items.
// ----------------------------------------------------------------------------
interface mbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  rx_byte;
  logic [5:0]  local_addr;
  logic [15:0] local_value;
  modport source (output valid, func, rx_byte, local_addr, local_value, input ready);
  modport sink   (input valid, func, rx_byte, local_addr, local_value, output ready);
endinterface

interface mbs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] read_value;
  modport source (output valid, result_kind, tx_byte, last, read_value, input ready);
  modport sink   (input valid, result_kind, tx_byte, last, read_value, output ready);
endinterface

// ----- hdl/mbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_ctrl
// Sequencer: event dispatch, frame checks and response byte order.
// ----------------------------------------------------------------------------
module mbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_func_i,
  output logic            in_ready_o,
  input  mbs_pkg::stat_t  stat_i,
  output mbs_pkg::cmd_t   cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LRD      = 5'd1;
  localparam logic [4:0] S_CHECK    = 5'd2;
  localparam logic [4:0] S_EX_ADDR  = 5'd3;
  localparam logic [4:0] S_EX_FC    = 5'd4;
  localparam logic [4:0] S_EX_CODE  = 5'd5;
  localparam logic [4:0] S_RSP_ADDR = 5'd6;
  localparam logic [4:0] S_RSP_FC   = 5'd7;
  localparam logic [4:0] S_RSP_CNT  = 5'd8;
  localparam logic [4:0] S_RD_REQ   = 5'd9;
  localparam logic [4:0] S_RD_HI    = 5'd10;
  localparam logic [4:0] S_RD_LO    = 5'd11;
  localparam logic [4:0] S_BUF_REQ  = 5'd12;
  localparam logic [4:0] S_BUF_EM   = 5'd13;
  localparam logic [4:0] S_CRC_LO   = 5'd14;
  localparam logic [4:0] S_CRC_HI   = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0] state_q, state_d;
  logic       exc2_q, exc2_d;
  logic       acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    exc2_d  = exc2_q;
    cmd_o   = '0;
    cmd_o.sel = mbs_pkg::SEL_ADDR;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (in_func_i)
            mbs_pkg::FUNC_RX_BYTE: cmd_o.store_byte = 1'b1;
            mbs_pkg::FUNC_TICK: begin
              if (stat_i.frame_due) state_d = S_CHECK;
              else cmd_o.tick_inc = 1'b1;
            end
            mbs_pkg::FUNC_LWRITE: cmd_o.hw_local = 1'b1;
            default: begin
              cmd_o.hr_local = 1'b1;
              state_d = S_LRD;
            end
          endcase
        end
      end
      S_LRD: begin
        cmd_o.emit_local = 1'b1;
        if (stat_i.slot_free) state_d = S_IDLE;
      end
      S_CHECK: begin
        cmd_o.txcrc_init = 1'b1;
        cmd_o.cnt_clr    = 1'b1;
        priority if (!stat_i.hdr_ok) begin
          state_d = S_DONE;
        end else if (!stat_i.is_rd && !stat_i.is_wr) begin
          exc2_d  = 1'b0;
          state_d = S_EX_ADDR;
        end else if (stat_i.short8) begin
          state_d = S_DONE;
        end else if (stat_i.is_rd) begin
          exc2_d  = 1'b1;
          state_d = stat_i.rd_fault ? S_EX_ADDR : S_RSP_ADDR;
        end else begin
          exc2_d  = 1'b1;
          if (stat_i.wr_fault) begin
            state_d = S_EX_ADDR;
          end else begin
            cmd_o.hw_frame = 1'b1;
            state_d = S_BUF_REQ;
          end
        end
      end
      S_EX_ADDR, S_RSP_ADDR: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_ADDR;
        if (stat_i.slot_free) state_d = (state_q == S_EX_ADDR) ? S_EX_FC : S_RSP_FC;
      end
      S_EX_FC: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_FCX;
        if (stat_i.slot_free) state_d = S_EX_CODE;
      end
      S_EX_CODE: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = exc2_q ? mbs_pkg::SEL_EXC2 : mbs_pkg::SEL_EXC1;
        if (stat_i.slot_free) state_d = S_CRC_LO;
      end
      S_RSP_FC: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_FC3;
        if (stat_i.slot_free) state_d = S_RSP_CNT;
      end
      S_RSP_CNT: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_CNT;
        if (stat_i.slot_free) state_d = stat_i.q_zero ? S_CRC_LO : S_RD_REQ;
      end
      S_RD_REQ: begin
        cmd_o.hr_frame = 1'b1;
        state_d = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_RHI;
        if (stat_i.slot_free) state_d = S_RD_LO;
      end
      S_RD_LO: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_RLO;
        if (stat_i.slot_free) begin
          cmd_o.cnt_inc = 1'b1;
          state_d = stat_i.rd_last ? S_CRC_LO : S_RD_REQ;
        end
      end
      S_BUF_REQ: begin
        cmd_o.buf_rd = 1'b1;
        state_d = S_BUF_EM;
      end
      S_BUF_EM: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_BUF;
        if (stat_i.slot_free) begin
          cmd_o.cnt_inc = 1'b1;
          state_d = stat_i.echo_last ? S_CRC_LO : S_BUF_REQ;
        end
      end
      S_CRC_LO: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = mbs_pkg::SEL_CRCL;
        if (stat_i.slot_free) state_d = S_CRC_HI;
      end
      S_CRC_HI: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.last = 1'b1;
        cmd_o.sel  = mbs_pkg::SEL_CRCH;
        if (stat_i.slot_free) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.clear_frame = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      exc2_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      exc2_q  <= exc2_d;
    end
  end

endmodule

// ----- hdl/mbs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_dp
// Datapath: frame buffer, holding registers, CRC, counters, output register.
// ----------------------------------------------------------------------------
module mbs_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbs_pkg::cfg_t   cfg_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [5:0]      local_addr_i,
  input  logic [15:0]     local_value_i,
  input  mbs_pkg::cmd_t   cmd_i,
  output mbs_pkg::stat_t  stat_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic [15:0]     out_value_o
);

  localparam int unsigned AW = mbs_pkg::REG_AW;

  logic [7:0]  fbuf [mbs_pkg::FRAME_BYTES];
  logic [15:0] hregs [mbs_pkg::REG_DEPTH];
  logic [mbs_pkg::REG_DEPTH-1:0] hvalid_q;

  logic [mbs_pkg::LEN_W-1:0] len_q;
  logic [7:0]  idle_q;
  logic [15:0] crc_q, txcrc_q;
  logic [7:0]  hdr_q [6];
  logic [mbs_pkg::LEN_W-1:0] cnt_q;
  logic [7:0]  brd_q;
  logic [15:0] hrd_q;
  logic        hrd_vld_q;
  logic        ov_q, okind_q, olast_q;
  logic [7:0]  obyte_q;
  logic [15:0] oval_q;

  logic [15:0] a, q, hval;
  logic [16:0] a_plus_q;
  logic [mbs_pkg::LIM_W-1:0] lim;
  logic [AW-1:0] hw_addr, hr_addr;
  logic [15:0] hw_data;
  logic        hw_en, hr_en;
  logic [7:0]  tx;
  logic        slot_free;

  assign a        = {hdr_q[2], hdr_q[3]};
  assign q        = {hdr_q[4], hdr_q[5]};
  assign a_plus_q = {1'b0, a} + {1'b0, q};
  assign lim = (cfg_i.regs_used > 7'(mbs_pkg::REG_DEPTH)) ?
               mbs_pkg::LIM_W'(mbs_pkg::REG_DEPTH) : mbs_pkg::LIM_W'(cfg_i.regs_used);
  assign hval = hrd_vld_q ? hrd_q : 16'h0000;
  assign slot_free = !ov_q || out_ready_i;

  always_comb begin
    stat_o.slot_free = slot_free;
    stat_o.frame_due = (len_q != '0) && (idle_q >= cfg_i.gap_ticks);
    stat_o.hdr_ok    = (len_q >= mbs_pkg::LEN_W'(4)) && (hdr_q[0] == cfg_i.slave_addr)
                       && (crc_q == 16'h0000);
    stat_o.short8    = len_q < mbs_pkg::LEN_W'(8);
    stat_o.is_rd     = hdr_q[1] == mbs_pkg::FC_READ_HOLD;
    stat_o.is_wr     = hdr_q[1] == mbs_pkg::FC_WRITE_ONE;
    stat_o.rd_fault  = (q > 16'(mbs_pkg::MAX_READ)) || (a_plus_q > 17'(lim));
    stat_o.wr_fault  = a >= 16'(lim);
    stat_o.q_zero    = q == 16'h0000;
    stat_o.rd_last   = 16'(cnt_q) + 16'd1 == q;
    stat_o.echo_last = cnt_q + mbs_pkg::LEN_W'(3) == len_q;
  end

  always_comb begin
    unique case (cmd_i.sel)
      mbs_pkg::SEL_ADDR: tx = cfg_i.slave_addr;
      mbs_pkg::SEL_FCX:  tx = hdr_q[1] | mbs_pkg::FC_EXC_FLAG;
      mbs_pkg::SEL_EXC1: tx = mbs_pkg::EXC_ILL_FUNC;
      mbs_pkg::SEL_EXC2: tx = mbs_pkg::EXC_ILL_ADDR;
      mbs_pkg::SEL_FC3:  tx = mbs_pkg::FC_READ_HOLD;
      mbs_pkg::SEL_CNT:  tx = {hdr_q[5][6:0], 1'b0};
      mbs_pkg::SEL_RHI:  tx = hval[15:8];
      mbs_pkg::SEL_RLO:  tx = hval[7:0];
      mbs_pkg::SEL_BUF:  tx = brd_q;
      mbs_pkg::SEL_CRCL: tx = txcrc_q[7:0];
      mbs_pkg::SEL_CRCH: tx = txcrc_q[15:8];
      default:           tx = 8'h00;
    endcase
  end

  // holding register port select
  assign hw_en   = cmd_i.hw_local || cmd_i.hw_frame;
  assign hw_addr = cmd_i.hw_frame ? a[AW-1:0] : local_addr_i[AW-1:0];
  assign hw_data = cmd_i.hw_frame ? q : local_value_i;
  assign hr_en   = cmd_i.hr_local || cmd_i.hr_frame;
  assign hr_addr = cmd_i.hr_frame ? (a[AW-1:0] + cnt_q[AW-1:0]) : local_addr_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (hw_en) hregs[hw_addr] <= hw_data;
    if (hr_en) hrd_q <= hregs[hr_addr];
    if (cmd_i.store_byte && (len_q < mbs_pkg::LEN_W'(mbs_pkg::FRAME_BYTES)))
      fbuf[len_q[mbs_pkg::BUF_AW-1:0]] <= rx_byte_i;
    if (cmd_i.buf_rd) brd_q <= fbuf[cnt_q[mbs_pkg::BUF_AW-1:0]];
  end

  // header bytes kept in flops for the checks
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte && (len_q < mbs_pkg::LEN_W'(6)))
      hdr_q[len_q[2:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q  <= '0;
      hrd_vld_q <= 1'b0;
      len_q     <= '0;
      idle_q    <= '0;
      crc_q     <= mbs_pkg::CRC_INIT;
      txcrc_q   <= mbs_pkg::CRC_INIT;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (hw_en) hvalid_q[hw_addr] <= 1'b1;
      if (hr_en) hrd_vld_q <= hvalid_q[hr_addr];
      if (cmd_i.store_byte && (len_q < mbs_pkg::LEN_W'(mbs_pkg::FRAME_BYTES))) begin
        len_q  <= len_q + mbs_pkg::LEN_W'(1);
        crc_q  <= mbs_pkg::crc_byte(crc_q, rx_byte_i);
        idle_q <= '0;
      end
      if (cmd_i.tick_inc && (idle_q != 8'hFF)) idle_q <= idle_q + 8'd1;
      if (cmd_i.clear_frame) begin
        len_q  <= '0;
        idle_q <= '0;
        crc_q  <= mbs_pkg::CRC_INIT;
      end
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + mbs_pkg::LEN_W'(1);
      if (cmd_i.txcrc_init) txcrc_q <= mbs_pkg::CRC_INIT;
      else if (cmd_i.emit && (cmd_i.sel != mbs_pkg::SEL_CRCL) &&
               (cmd_i.sel != mbs_pkg::SEL_CRCH))
        txcrc_q <= mbs_pkg::crc_byte(txcrc_q, tx);
      if ((cmd_i.emit || cmd_i.emit_local) && slot_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && slot_free) begin
      okind_q <= 1'b0;
      obyte_q <= tx;
      olast_q <= cmd_i.last;
      oval_q  <= 16'h0000;
    end else if (cmd_i.emit_local && slot_free) begin
      okind_q <= 1'b1;
      obyte_q <= 8'h00;
      olast_q <= 1'b1;
      oval_q  <= hval;
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_value_o = oval_q;

endmodule

// ----- hdl/modbus_rtu_holding_register_slave.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_holding_register_slave
// Modbus RTU slave over 64 holding registers with local access port.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when      | payload
//  in_i    | in  | valid && ready     | func, rx_byte, local_addr, local_value
//  out_o   | out | valid && ready     | result_kind, tx_byte, last, read_value
//  apb     | in  | psel&penable&pwrite| slave_address, regs_in_use, gap_ticks
//
//  Received bytes, local writes and ticks that do not close a frame leave the
//  sequencer idle; a local read waits in its own state for the output register.
//  A processed frame emits at most one response byte per cycle, plus a request
//  state per register or echoed byte for the registered memory read; the
//  sequencer stalls while the output register is full.
//  Reset is asynchronous; the holding registers read as zero through per-entry
//  valid flops, the frame buffer needs no clearing.
// ----------------------------------------------------------------------------
module modbus_rtu_holding_register_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbs_in_if.sink      in_i,
  mbs_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mbs_pkg::cfg_t  cfg_q;
  mbs_pkg::cmd_t  cmd;
  mbs_pkg::stat_t stat;
  logic           cfg_we;

  // configuration registers, written in the APB access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_addr <= mbs_pkg::RST_SLAVE_ADDR;
      cfg_q.regs_used  <= mbs_pkg::RST_REGS_USED;
      cfg_q.gap_ticks  <= mbs_pkg::RST_GAP_TICKS;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        mbs_pkg::CFG_SLAVE_ADDR: cfg_q.slave_addr <= pwdata[7:0];
        mbs_pkg::CFG_REGS_USED:  cfg_q.regs_used  <= pwdata[6:0];
        mbs_pkg::CFG_GAP_TICKS:  cfg_q.gap_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mbs_pkg::CFG_SLAVE_ADDR: prdata = {24'h0, cfg_q.slave_addr};
      mbs_pkg::CFG_REGS_USED:  prdata = {25'h0, cfg_q.regs_used};
      mbs_pkg::CFG_GAP_TICKS:  prdata = {24'h0, cfg_q.gap_ticks};
      default:                 prdata = 32'h0;
    endcase
  end

  // sequencer: accepts an event only when idle
  mbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, CRC and the output register that decouples the result side
  mbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .rx_byte_i     (in_i.rx_byte),
    .local_addr_i  (in_i.local_addr),
    .local_value_i (in_i.local_value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_kind_o    (out_o.result_kind),
    .out_byte_o    (out_o.tx_byte),
    .out_last_o    (out_o.last),
    .out_value_o   (out_o.read_value)
  );

endmodule

// ----- hdl/mbs_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_chk
// Port-level checks for the Modbus slave, bound to the top level.
// ----------------------------------------------------------------------------
module mbs_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic       out_last_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_byte_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_func_i == mbs_pkg::FUNC_RX_BYTE) |=> in_ready_i)
    else $error("byte store did not return to idle");

  a_lread_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_func_i == mbs_pkg::FUNC_LREAD) |=> !in_ready_i)
    else $error("local read not serviced");

  // a local read result is always a single, final transfer
  a_local_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> out_last_i)
    else $error("local read result malformed");

endmodule

bind modbus_rtu_holding_register_slave mbs_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.result_kind),
  .out_last_i  (out_o.last)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU holding register slave: directed and
// random frames, ticks and local accesses, predicted and compared per result.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [5:0]  local_addr;
    logic [15:0] local_value;
  } event_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] read_value;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mbs_in_if  ev_ch ();
  mbs_out_if rs_ch ();

  modbus_rtu_holding_register_slave DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_ch.sink),
    .out_o   (rs_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow state of the slave
  logic [7:0]  frm_buf [mbs_pkg::FRAME_BYTES];
  int unsigned frm_len;
  logic [7:0]  quiet_ticks;
  logic [15:0] hold_regs [mbs_pkg::REG_DEPTH];
  logic [15:0] rx_crc;
  logic [7:0]  my_addr;
  logic [6:0]  regs_used;
  logic [7:0]  gap_limit;
  logic [15:0] tx_crc;

  event_t pending_events[$];
  reply_t expected_replies[$];
  int mismatches = 0;
  int replies_seen = 0;
  int events_sent = 0;
  int frames_answered = 0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void push_tx(logic [7:0] b);
    reply_t r;
    r = '{result_kind: 1'b0, tx_byte: b, last: 1'b0, read_value: 16'h0};
    expected_replies.push_back(r);
    tx_crc = crc_step(tx_crc, b);
  endfunction

  function automatic void push_crc();
    logic [15:0] c;
    c = tx_crc;
    push_tx(c[7:0]);
    push_tx(c[15:8]);
    expected_replies[$].last = 1'b1;
    frames_answered++;
  endfunction

  function automatic void push_exception(logic [7:0] code);
    tx_crc = mbs_pkg::CRC_INIT;
    push_tx(my_addr);
    push_tx(frm_buf[1] | mbs_pkg::FC_EXC_FLAG);
    push_tx(code);
    push_crc();
  endfunction

  // answer to a completed frame
  function automatic void answer_frame();
    int unsigned lim, a, q;
    logic [7:0] fc;
    if (frm_len < 4) return;
    if (frm_buf[0] != my_addr) return;
    if (rx_crc != 16'h0) return;
    fc = frm_buf[1];
    if (fc != mbs_pkg::FC_READ_HOLD && fc != mbs_pkg::FC_WRITE_ONE) begin
      push_exception(mbs_pkg::EXC_ILL_FUNC);
      return;
    end
    if (frm_len < 8) return;
    lim = (regs_used < mbs_pkg::REG_DEPTH) ? regs_used : mbs_pkg::REG_DEPTH;
    a = 32'({frm_buf[2], frm_buf[3]});
    q = 32'({frm_buf[4], frm_buf[5]});
    tx_crc = mbs_pkg::CRC_INIT;
    if (fc == mbs_pkg::FC_READ_HOLD) begin
      if (q > mbs_pkg::MAX_READ || a + q > lim) begin
        push_exception(mbs_pkg::EXC_ILL_ADDR);
        return;
      end
      push_tx(my_addr);
      push_tx(mbs_pkg::FC_READ_HOLD);
      push_tx(8'(q * 2));
      for (int unsigned i = 0; i < q; i++) begin
        push_tx(hold_regs[a + i][15:8]);
        push_tx(hold_regs[a + i][7:0]);
      end
      push_crc();
      return;
    end
    if (a >= lim) begin
      push_exception(mbs_pkg::EXC_ILL_ADDR);
      return;
    end
    hold_regs[a] = q[15:0];
    for (int unsigned i = 0; i + 2 < frm_len; i++) push_tx(frm_buf[i]);
    push_crc();
  endfunction

  function automatic void predict_event(event_t e);
    reply_t r;
    case (e.func)
      mbs_pkg::FUNC_RX_BYTE: begin
        if (frm_len < mbs_pkg::FRAME_BYTES) begin
          frm_buf[frm_len] = e.rx_byte;
          frm_len++;
          rx_crc = crc_step(rx_crc, e.rx_byte);
          quiet_ticks = 8'd0;
        end
      end
      mbs_pkg::FUNC_TICK: begin
        if (frm_len > 0 && quiet_ticks >= gap_limit) begin
          answer_frame();
          frm_len = 0;
          quiet_ticks = 8'd0;
          rx_crc = mbs_pkg::CRC_INIT;
        end else if (quiet_ticks != 8'hFF) begin
          quiet_ticks++;
        end
      end
      mbs_pkg::FUNC_LWRITE: hold_regs[e.local_addr] = e.local_value;
      default: begin
        r = '{result_kind: 1'b1, tx_byte: 8'h0, last: 1'b1,
              read_value: hold_regs[e.local_addr]};
        expected_replies.push_back(r);
      end
    endcase
  endfunction

  // driver: one event per transfer, random gap before each
  int ev_wait = 0;
  bit ev_taken = 1'b0;
  initial begin
    ev_ch.valid = 1'b0;
    ev_ch.func = '0;
    ev_ch.rx_byte = '0;
    ev_ch.local_addr = '0;
    ev_ch.local_value = '0;
  end

  // transfer seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && ev_ch.valid && ev_ch.ready) begin
      predict_event({ev_ch.func, ev_ch.rx_byte, ev_ch.local_addr, ev_ch.local_value});
      events_sent++;
      ev_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ev_taken) begin
        ev_taken = 1'b0;
        ev_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (ev_wait == 0 && pending_events.size() > 0) begin
          {ev_ch.func, ev_ch.rx_byte, ev_ch.local_addr, ev_ch.local_value} =
            pending_events.pop_front();
        end else begin
          ev_ch.valid <= 1'b0;
        end
      end else if (!ev_ch.valid) begin
        if (ev_wait > 0) ev_wait--;
        else if (pending_events.size() > 0) begin
          {ev_ch.func, ev_ch.rx_byte, ev_ch.local_addr, ev_ch.local_value} =
            pending_events.pop_front();
          ev_ch.valid <= 1'b1;
        end
      end
    end
  end

  // monitor: ready with random stalls, check at the rising edge
  int rs_wait = 0;
  initial rs_ch.ready = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) rs_ch.ready <= 1'b0;
    else if (rs_wait > 0) begin
      rs_wait--;
      rs_ch.ready <= 1'b0;
    end else begin
      rs_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    reply_t got, exp_r;
    if (rst_ni && rs_ch.valid && rs_ch.ready) begin
      got = '{rs_ch.result_kind, rs_ch.tx_byte, rs_ch.last, rs_ch.read_value};
      replies_seen++;
      rs_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected result %h", got);
      end else begin
        exp_r = expected_replies.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp kind=%0d tx=%h last=%0d rd=%h got kind=%0d tx=%h last=%0d rd=%h",
                     exp_r.result_kind, exp_r.tx_byte, exp_r.last, exp_r.read_value,
                     got.result_kind, got.tx_byte, got.last, got.read_value);
        end
      end
    end
  end

  // ---- stimulus helpers ----
  task automatic queue_event(logic [1:0] f, logic [7:0] b, logic [5:0] la, logic [15:0] lv);
    pending_events.push_back({f, b, la, lv});
  endtask

  task automatic queue_frame(logic [7:0] bytes[$], bit good_crc);
    logic [15:0] c;
    c = mbs_pkg::CRC_INIT;
    foreach (bytes[i]) begin
      queue_event(mbs_pkg::FUNC_RX_BYTE, bytes[i], 6'($urandom), 16'($urandom));
      c = crc_step(c, bytes[i]);
    end
    if (!good_crc) c ^= 16'h0001 << $urandom_range(0, 15);
    queue_event(mbs_pkg::FUNC_RX_BYTE, c[7:0], 6'($urandom), 16'($urandom));
    queue_event(mbs_pkg::FUNC_RX_BYTE, c[15:8], 6'($urandom), 16'($urandom));
  endtask

  // enough ticks to close the frame (gap + 1)
  task automatic queue_gap();
    for (int i = 0; i <= gap_limit; i++)
      queue_event(mbs_pkg::FUNC_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || ev_ch.valid || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      mbs_pkg::CFG_SLAVE_ADDR: my_addr = val[7:0];
      mbs_pkg::CFG_REGS_USED:  regs_used = val[6:0];
      default:                 gap_limit = val[7:0];
    endcase
  endtask

  task automatic queue_rw_frame(logic [7:0] fc, logic [15:0] a, logic [15:0] q, bit good);
    logic [7:0] b[$];
    b = '{my_addr, fc, a[15:8], a[7:0], q[15:8], q[7:0]};
    queue_frame(b, good);
    queue_gap();
  endtask

  // random phase: well-formed frames mixed with local accesses, ticks and noise
  task automatic random_phase(int n);
    logic [7:0] b[$];
    int k, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'($urandom_range(0, 40)),
                                $urandom_range(0, 8) == 0 ? 16'($urandom_range(0, 40))
                                                          : 16'($urandom_range(0, 8)),
                                $urandom_range(0, 7) != 0);
        3, 4: queue_rw_frame(mbs_pkg::FC_WRITE_ONE, 16'($urandom_range(0, 70)),
                             16'($urandom), 1'b1);
        5: queue_event(mbs_pkg::FUNC_LWRITE, 8'($urandom), 6'($urandom), 16'($urandom));
        6: queue_event(mbs_pkg::FUNC_LREAD, 8'($urandom), 6'($urandom), 16'($urandom));
        7: begin
          b = '{};
          k = $urandom_range(0, 10);
          b.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : my_addr);
          for (int j = 0; j < k; j++) b.push_back(8'($urandom));
          queue_frame(b, 1'($urandom_range(0, 1)));
          queue_gap();
        end
        8: queue_event(mbs_pkg::FUNC_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
        default: queue_event(mbs_pkg::FUNC_RX_BYTE, 8'($urandom), 6'($urandom),
                             16'($urandom));
      endcase
    end
    // flush any stray partial frame
    queue_event(mbs_pkg::FUNC_TICK, 8'd0, 6'd0, 16'd0);
    queue_gap();
  endtask

  initial begin
    logic [7:0] b[$];
    frm_len = 0; quiet_ticks = 0; rx_crc = mbs_pkg::CRC_INIT;
    my_addr = mbs_pkg::RST_SLAVE_ADDR;
    regs_used = mbs_pkg::RST_REGS_USED;
    gap_limit = mbs_pkg::RST_GAP_TICKS;
    foreach (hold_regs[i]) hold_regs[i] = 16'h0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed at reset configuration: local extremes and one read
    queue_event(mbs_pkg::FUNC_LREAD, 8'hFF, 6'd63, 16'hFFFF);
    queue_event(mbs_pkg::FUNC_LWRITE, 8'h00, 6'd0, 16'hFFFF);
    queue_event(mbs_pkg::FUNC_LWRITE, 8'hFF, 6'd63, 16'h0000);
    queue_event(mbs_pkg::FUNC_LWRITE, 8'h5A, 6'd1, 16'hA5C3);
    queue_event(mbs_pkg::FUNC_LREAD, 8'h00, 6'd0, 16'h0);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd0, 16'd3, 1'b1);
    drain();

    // short gap keeps the remaining frames compact
    apb_write(mbs_pkg::CFG_GAP_TICKS, 32'd1);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd0, 16'd0, 1'b1);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd0, 16'(mbs_pkg::MAX_READ + 1), 1'b1);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd63, 16'd2, 1'b1);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd35, 16'(mbs_pkg::MAX_READ), 1'b1);
    queue_rw_frame(mbs_pkg::FC_WRITE_ONE, 16'd5, 16'hBEEF, 1'b1);
    queue_rw_frame(mbs_pkg::FC_WRITE_ONE, 16'd64, 16'h1234, 1'b1);
    queue_rw_frame(mbs_pkg::FC_WRITE_ONE, 16'd2, 16'h1111, 1'b0);
    b = '{my_addr, 8'h10}; queue_frame(b, 1'b1); queue_gap();
    b = '{my_addr, mbs_pkg::FC_READ_HOLD, 8'h00}; queue_frame(b, 1'b1); queue_gap();
    b = '{my_addr}; queue_frame(b, 1'b1); queue_gap();
    b = '{8'h00, mbs_pkg::FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};
    queue_frame(b, 1'b1); queue_gap();
    // overflow the buffer, then gap
    for (int i = 0; i < 66; i++) queue_event(mbs_pkg::FUNC_RX_BYTE, 8'($urandom), 6'd0, 16'd0);
    queue_gap();
    drain();

    apb_write(mbs_pkg::CFG_SLAVE_ADDR, 32'd247);
    apb_write(mbs_pkg::CFG_REGS_USED, 32'd0);
    queue_rw_frame(mbs_pkg::FC_READ_HOLD, 16'd0, 16'd0, 1'b1);
    queue_rw_frame(mbs_pkg::FC_WRITE_ONE, 16'd0, 16'h7, 1'b1);
    random_phase(3);
    drain();

    apb_write(mbs_pkg::CFG_SLAVE_ADDR, $urandom_range(2, 246));
    apb_write(mbs_pkg::CFG_REGS_USED, 32'd127);
    apb_write(mbs_pkg::CFG_GAP_TICKS, 32'd2);
    random_phase(4);
    drain();

    $display("tb: %0d events in, %0d results checked, %0d frames answered",
             events_sent, replies_seen, frames_answered);
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mbs_pkg.sv
hdl/mbs_if.sv
hdl/mbs_ctrl.sv
hdl/mbs_dp.sv
hdl/modbus_rtu_holding_register_slave.sv
hdl/mbs_chk.sv
sim/tb.sv
